>>> rtl/core/ilid_pkg.sv
// ilid_pkg: command codes, status codes and sequencer state type for the indexed list core
// no dependencies; used by indexed_list_insert_delete_core
`default_nettype none

package ilid_pkg;

   localparam logic [2:0] CMD_APPEND = 3'd0;
   localparam logic [2:0] CMD_INSERT = 3'd1;
   localparam logic [2:0] CMD_DELETE = 3'd2;
   localparam logic [2:0] CMD_READ   = 3'd3;
   localparam logic [2:0] CMD_EDIT   = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;

   localparam int unsigned RSP_WORD_BITS = 32;
   localparam int unsigned POS_BITS      = 7;
   localparam int unsigned CNT_OUT_BITS  = 7;

   typedef enum logic [4:0] {
      ST_IDLE       = 5'b00001,
      ST_SHIFT_UP   = 5'b00010,
      ST_SHIFT_DOWN = 5'b00100,
      ST_PLACE      = 5'b01000,
      ST_DONE       = 5'b10000
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/ilid_ram.sv
// ilid_ram: generic simple dual port RAM, one write port and one registered read port
// no dependencies
`default_nettype none

module ilid_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/indexed_list_insert_delete_core.sv
// indexed_list_insert_delete_core: ordered list in a RAM with append, insert, delete, read, edit
// depends on ilid_pkg and ilid_ram
//
//   channel | direction | ports                                            | handshake
//   req     | in        | req_command, req_position, req_value             | req_valid/req_ready
//   rsp     | out       | rsp_read_word, rsp_status, rsp_element_count     | rsp_valid/rsp_ready
//
// append, read, edit, tail insert, delete of the last element, rejected commands: straight from
// accept to the done state; other inserts run SHIFT_UP then PLACE, other deletes run SHIFT_DOWN,
// one element moved per cycle through the single RAM read port and write port
// req_ready is high only while the sequencer is idle; a waiting result does not block it
// a stalled result holds the sequencer in its last state until the output register frees
// synchronous active-high reset clears count, state and output valid; RAM is not cleared
`default_nettype none

module indexed_list_insert_delete_core #(
   parameter int unsigned DEPTH      = 64,
   parameter int unsigned WORD_WIDTH = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_command,
   input  wire logic [6:0]         req_position,
   input  wire logic signed [31:0] req_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_read_word,
   output logic [1:0]              rsp_status,
   output logic [6:0]              rsp_element_count
);

   localparam int unsigned ADDR_W  = $clog2(DEPTH);
   localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CMP_W   = (COUNT_W > ilid_pkg::POS_BITS) ? COUNT_W
                                                                    : ilid_pkg::POS_BITS;

   ilid_pkg::state_type state_ff, state_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic [WORD_WIDTH-1:0] value_ff, value_in;
   logic [1:0]            status_ff, status_in;
   logic                  rd_ok_ff, rd_ok_in;
   logic                  rd_bad_ff, rd_bad_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]    rsp_word_ff, rsp_word_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [6:0]            rsp_count_ff, rsp_count_in;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [WORD_WIDTH-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [WORD_WIDTH-1:0] ram_rd_data;

   logic                  req_fire;
   logic [CMP_W-1:0]      pos_ext, cnt_ext;
   logic                  pos_gt_cnt, pos_ge_cnt, is_full, pos_is_last;
   logic [WORD_WIDTH-1:0] req_word;
   logic [ADDR_W-1:0]     last_addr, req_addr;

   ilid_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == ilid_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign pos_ext     = CMP_W'(req_position);
   assign cnt_ext     = CMP_W'(count_ff);
   assign pos_gt_cnt  = pos_ext > cnt_ext;
   assign pos_ge_cnt  = pos_ext >= cnt_ext;
   assign is_full     = count_ff == COUNT_W'(DEPTH);
   assign req_word    = WORD_WIDTH'($unsigned(req_value));
   assign last_addr   = ADDR_W'(count_ff - 1'b1);
   assign req_addr    = ADDR_W'(req_position);
   assign pos_is_last = pos_ext == CMP_W'(count_ff - 1'b1);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      value_in    = value_ff;
      status_in   = status_ff;
      rd_ok_in    = rd_ok_ff;
      rd_bad_in   = rd_bad_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ilid_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in  = ilid_pkg::ST_DONE;
               status_in = ilid_pkg::STATUS_OK;
               rd_ok_in  = 1'b0;
               rd_bad_in = 1'b0;
               pos_in    = req_addr;
               value_in  = req_word;
               case (req_command)
                  ilid_pkg::CMD_APPEND: begin
                     if (is_full) begin
                        status_in = ilid_pkg::STATUS_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = ADDR_W'(count_ff);
                        ram_wr_data = req_word;
                        count_in    = COUNT_W'(count_ff + 1'b1);
                     end
                  end
                  ilid_pkg::CMD_INSERT: begin
                     if (pos_gt_cnt) begin
                        status_in = ilid_pkg::STATUS_BAD_INDEX;
                     end else if (is_full) begin
                        status_in = ilid_pkg::STATUS_FULL;
                     end else if (pos_ge_cnt) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = req_addr;
                        ram_wr_data = req_word;
                        count_in    = COUNT_W'(count_ff + 1'b1);
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = last_addr;
                        idx_in      = last_addr;
                        state_in    = ilid_pkg::ST_SHIFT_UP;
                     end
                  end
                  ilid_pkg::CMD_DELETE: begin
                     if (pos_ge_cnt) begin
                        status_in = ilid_pkg::STATUS_BAD_INDEX;
                     end else if (pos_is_last) begin
                        count_in = COUNT_W'(count_ff - 1'b1);
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(req_addr + 1'b1);
                        idx_in      = ADDR_W'(req_addr + 1'b1);
                        state_in    = ilid_pkg::ST_SHIFT_DOWN;
                     end
                  end
                  ilid_pkg::CMD_READ: begin
                     if (pos_ge_cnt) begin
                        status_in = ilid_pkg::STATUS_BAD_INDEX;
                        rd_bad_in = 1'b1;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_addr;
                        rd_ok_in    = 1'b1;
                     end
                  end
                  ilid_pkg::CMD_EDIT: begin
                     if (pos_ge_cnt) begin
                        status_in = ilid_pkg::STATUS_BAD_INDEX;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = req_addr;
                        ram_wr_data = req_word;
                     end
                  end
                  default: begin
                     status_in = ilid_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         ilid_pkg::ST_SHIFT_UP: begin
            // data of idx_ff arrived; move it up one place
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(idx_ff + 1'b1);
            ram_wr_data = ram_rd_data;
            if (idx_ff == pos_ff) begin
               state_in = ilid_pkg::ST_PLACE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(idx_ff - 1'b1);
               idx_in      = ADDR_W'(idx_ff - 1'b1);
            end
         end
         ilid_pkg::ST_PLACE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = value_ff;
            count_in    = COUNT_W'(count_ff + 1'b1);
            state_in    = ilid_pkg::ST_DONE;
         end
         ilid_pkg::ST_SHIFT_DOWN: begin
            // data of idx_ff arrived; move it down one place
            ram_wr_en   = 1'b1;
            ram_wr_addr = ADDR_W'(idx_ff - 1'b1);
            ram_wr_data = ram_rd_data;
            if (idx_ff == last_addr) begin
               count_in = COUNT_W'(count_ff - 1'b1);
               state_in = ilid_pkg::ST_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = ADDR_W'(idx_ff + 1'b1);
               idx_in      = ADDR_W'(idx_ff + 1'b1);
            end
         end
         ilid_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = ilid_pkg::CNT_OUT_BITS'(count_ff);
               if (rd_ok_ff) begin
                  rsp_word_in = ilid_pkg::RSP_WORD_BITS'(ram_rd_data);
               end else if (rd_bad_ff) begin
                  rsp_word_in = ilid_pkg::RSP_WORD_BITS'({WORD_WIDTH{1'b1}});
               end else begin
                  rsp_word_in = '0;
               end
               state_in = ilid_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ilid_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilid_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      rd_ok_ff      <= rd_ok_in;
      rd_bad_ff     <= rd_bad_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_word     = rsp_word_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;

   // count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("element count above depth");

   // count moves by at most one per transaction
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) && !$past(reset) |->
         (count_ff == COUNT_W'($past(count_ff) + 1'b1)) ||
         (count_ff == COUNT_W'($past(count_ff) - 1'b1)))
      else $error("element count jumped");

   // upward shift never passes the insert position
   a_shift_up_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ilid_pkg::ST_SHIFT_UP |-> idx_ff >= pos_ff && idx_ff < last_addr + 1'b1)
      else $error("upward shift index out of range");

   // downward shift stays inside the stored elements
   a_shift_down_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ilid_pkg::ST_SHIFT_DOWN |-> COUNT_W'(idx_ff) < count_ff && idx_ff > pos_ff)
      else $error("downward shift index out of range");

   // a new result is loaded only from the done state
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ilid_pkg::ST_DONE)
      else $error("result raised outside done state");

endmodule

`default_nettype wire

>>> test/indexed_list_insert_delete_core_tb.sv
// indexed_list_insert_delete_core_tb: self-checking bench for the indexed list core
// tracks the list in a local model, checks every reply in order, random handshake stalls
// depends on ilid_pkg and indexed_list_insert_delete_core
`timescale 1ns / 1ps

module indexed_list_insert_delete_core_tb;

   localparam int unsigned LIST_DEPTH = 64;
   localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
   localparam logic [2:0] CMD_RESERVED_HI = 3'd7;
   localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] WORD_ALL_ONES = -32'sd1;
   localparam int unsigned TAIL_ITEMS = 150;

   typedef struct packed {
      logic signed [31:0] word;
      logic [1:0]         status;
      logic [6:0]         count;
   } list_reply_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_command = ilid_pkg::CMD_APPEND;
   logic [6:0]         req_position = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_read_word;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_element_count;

   logic signed [31:0] list_words [0:LIST_DEPTH-1];
   int unsigned        list_count = 0;
   list_reply_type     pending_replies [$];
   int unsigned        fault_count = 0;
   bit                 idling_on = 1'b1;

   indexed_list_insert_delete_core #(
      .DEPTH      (LIST_DEPTH),
      .WORD_WIDTH (32)
   ) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_word     (rsp_read_word),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #8ms;
      $display("DONE: errors detected");
      $finish;
   end

   // list model: applies one command and returns the reply it causes
   function automatic list_reply_type step_list(input logic [2:0] cmd, input logic [6:0] pos,
                                                input logic signed [31:0] val);
      list_reply_type reply;
      int unsigned i;
      reply.word   = '0;
      reply.status = ilid_pkg::STATUS_OK;
      case (cmd)
         ilid_pkg::CMD_APPEND: begin
            if (list_count >= LIST_DEPTH) begin
               reply.status = ilid_pkg::STATUS_FULL;
            end else begin
               list_words[list_count] = val;
               list_count++;
            end
         end
         ilid_pkg::CMD_INSERT: begin
            if (pos > list_count) begin
               reply.status = ilid_pkg::STATUS_BAD_INDEX;
            end else if (list_count >= LIST_DEPTH) begin
               reply.status = ilid_pkg::STATUS_FULL;
            end else begin
               for (i = list_count; i > pos; i--) list_words[i] = list_words[i-1];
               list_words[pos] = val;
               list_count++;
            end
         end
         ilid_pkg::CMD_DELETE: begin
            if (pos >= list_count) begin
               reply.status = ilid_pkg::STATUS_BAD_INDEX;
            end else begin
               for (i = pos; i + 1 < list_count; i++) list_words[i] = list_words[i+1];
               list_count--;
            end
         end
         ilid_pkg::CMD_READ: begin
            if (pos >= list_count) begin
               reply.status = ilid_pkg::STATUS_BAD_INDEX;
               reply.word   = WORD_ALL_ONES;
            end else begin
               reply.word = list_words[pos];
            end
         end
         ilid_pkg::CMD_EDIT: begin
            if (pos >= list_count) reply.status = ilid_pkg::STATUS_BAD_INDEX;
            else list_words[pos] = val;
         end
         default: ;
      endcase
      reply.count = list_count[6:0];
      return reply;
   endfunction

   // one transaction on the request side, with an optional idle burst ahead of it
   task automatic send_list_command(input logic [2:0] cmd, input logic [6:0] pos,
                                    input logic signed [31:0] val);
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_command  <= cmd;
      req_position <= pos;
      req_value    <= val;
      req_valid    <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_replies.push_back(step_list(cmd, pos, val));
   endtask

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(0, 19))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return WORD_ALL_ONES;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_empty_list();
      logic [2:0] cmd;
      send_list_command(ilid_pkg::CMD_READ, 7'd0, '0);
      send_list_command(ilid_pkg::CMD_DELETE, 7'd0, '0);
      send_list_command(ilid_pkg::CMD_EDIT, 7'd0, WORD_MAX);
      send_list_command(ilid_pkg::CMD_INSERT, 7'd1, WORD_MAX);
      send_list_command(ilid_pkg::CMD_READ, 7'd127, '0);
      for (cmd = CMD_RESERVED_LO; cmd <= CMD_RESERVED_HI && cmd != 3'd0; cmd++)
         send_list_command(cmd, 7'd0, WORD_ALL_ONES);
   endtask

   task automatic test_basic_ops();
      send_list_command(ilid_pkg::CMD_APPEND, 7'd127, WORD_MAX);
      send_list_command(ilid_pkg::CMD_APPEND, 7'd0, WORD_MIN);
      send_list_command(ilid_pkg::CMD_INSERT, 7'd0, WORD_ALL_ONES);
      send_list_command(ilid_pkg::CMD_INSERT, 7'd3, '0);
      send_list_command(ilid_pkg::CMD_INSERT, 7'd5, 32'sh1234_5678);
      send_list_command(ilid_pkg::CMD_READ, 7'd0, '0);
      send_list_command(ilid_pkg::CMD_READ, 7'd1, '0);
      send_list_command(ilid_pkg::CMD_READ, 7'd2, '0);
      send_list_command(ilid_pkg::CMD_READ, 7'd3, '0);
      send_list_command(ilid_pkg::CMD_EDIT, 7'd2, 32'sh5a5a_a5a5);
      send_list_command(ilid_pkg::CMD_READ, 7'd2, '0);
      send_list_command(CMD_RESERVED_HI, 7'd1, WORD_MAX);
      send_list_command(ilid_pkg::CMD_DELETE, 7'd3, '0);
      send_list_command(ilid_pkg::CMD_DELETE, 7'd0, '0);
      send_list_command(ilid_pkg::CMD_READ, 7'd0, '0);
      send_list_command(ilid_pkg::CMD_READ, 7'd64, '0);
      send_list_command(ilid_pkg::CMD_INSERT, 7'd64, WORD_MIN);
      send_list_command(ilid_pkg::CMD_EDIT, 7'd127, WORD_MIN);
      send_list_command(ilid_pkg::CMD_DELETE, 7'd64, '0);
   endtask

   task automatic test_full_store();
      while (list_count < LIST_DEPTH)
         send_list_command(ilid_pkg::CMD_APPEND, 7'($urandom), pick_word());
      send_list_command(ilid_pkg::CMD_APPEND, 7'd0, WORD_MAX);
      send_list_command(ilid_pkg::CMD_INSERT, 7'd0, WORD_MAX);
      send_list_command(ilid_pkg::CMD_INSERT, 7'd64, WORD_MAX);
      send_list_command(ilid_pkg::CMD_INSERT, 7'd65, WORD_MAX);
      send_list_command(ilid_pkg::CMD_READ, 7'd63, '0);
      send_list_command(ilid_pkg::CMD_READ, 7'd64, '0);
      send_list_command(ilid_pkg::CMD_EDIT, 7'd63, WORD_MIN);
      send_list_command(ilid_pkg::CMD_DELETE, 7'd0, '0);
      send_list_command(ilid_pkg::CMD_INSERT, 7'd0, WORD_ALL_ONES);
      send_list_command(ilid_pkg::CMD_READ, 7'd0, '0);
      send_list_command(ilid_pkg::CMD_DELETE, 7'd63, '0);
      send_list_command(ilid_pkg::CMD_INSERT, 7'd63, 32'sh0f0f_f0f0);
      send_list_command(ilid_pkg::CMD_READ, 7'd63, '0);
   endtask

   // random traffic that drifts the list between empty and full
   task automatic test_random_traffic(input int unsigned items);
      int unsigned n;
      int unsigned roll;
      bit          growing;
      logic [2:0]  cmd;
      logic [6:0]  pos;
      growing = 1'b0;
      for (n = 0; n < items; n++) begin
         if (n == items - TAIL_ITEMS) idling_on = 1'b0;
         if (list_count == 0) growing = 1'b1;
         else if (list_count == LIST_DEPTH && $urandom_range(0, 5) == 0) growing = 1'b0;
         else if ($urandom_range(0, 59) == 0) growing = !growing;
         roll = $urandom_range(0, 99);
         if (roll < 3) cmd = 3'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
         else if (roll < (growing ? 30 : 12)) cmd = ilid_pkg::CMD_APPEND;
         else if (roll < (growing ? 60 : 26)) cmd = ilid_pkg::CMD_INSERT;
         else if (roll < (growing ? 72 : 66)) cmd = ilid_pkg::CMD_DELETE;
         else if (roll < 86) cmd = ilid_pkg::CMD_READ;
         else cmd = ilid_pkg::CMD_EDIT;
         if ($urandom_range(0, 99) < 12) begin
            pos = 7'($urandom_range(list_count, 127));
            if (cmd == ilid_pkg::CMD_INSERT && pos == list_count) pos = pos + 7'd1;
         end else if (cmd == ilid_pkg::CMD_INSERT || list_count == 0) begin
            pos = 7'($urandom_range(0, list_count));
         end else begin
            pos = 7'($urandom_range(0, list_count - 1));
         end
         send_list_command(cmd, pos, pick_word());
      end
   endtask

   // response side back-pressure in random bursts
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // reply checker, in order against the model
   always @(posedge clock) begin
      list_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            if (fault_count < 10)
               $display("unexpected transaction: word %0d status %0d count %0d",
                        rsp_read_word, rsp_status, rsp_element_count);
            fault_count++;
         end else begin
            want = pending_replies.pop_front();
            if (rsp_read_word !== want.word || rsp_status !== want.status ||
                rsp_element_count !== want.count) begin
               if (fault_count < 10)
                  $display("mismatch: expected word %0d status %0d count %0d, got %0d %0d %0d",
                           want.word, want.status, want.count,
                           rsp_read_word, rsp_status, rsp_element_count);
               fault_count++;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_basic_ops();
      test_full_store();
      test_random_traffic(1200);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/ilid_pkg.sv
rtl/core/ilid_ram.sv
rtl/core/indexed_list_insert_delete_core.sv
test/indexed_list_insert_delete_core_tb.sv
